### hw/rtl/mtep_pkg.sv
// ----------------------------------------------------------------------------
// mtep_pkg
// Shared types and constants of the track event parser.
// ----------------------------------------------------------------------------
package mtep_pkg;

    localparam logic [23:0] TEMPO_DEFAULT = 24'd500000;
    localparam logic [15:0] TPQ_DEFAULT   = 16'd480;

    localparam logic [7:0] BYTE_META  = 8'hFF;
    localparam logic [7:0] META_TEMPO = 8'h51;
    localparam logic [7:0] BYTE_SYSEX = 8'hF0;
    localparam logic [7:0] BYTE_ESC   = 8'hF7;
    localparam logic [3:0] TYPE_NOFF  = 4'h8;
    localparam logic [3:0] TYPE_NON   = 4'h9;
    localparam logic [3:0] TYPE_PROG  = 4'hC;
    localparam logic [3:0] TYPE_CPRS  = 4'hD;

    localparam logic [1:0] KIND_NOTE_ON  = 2'd0;
    localparam logic [1:0] KIND_NOTE_OFF = 2'd1;
    localparam logic [1:0] KIND_PROGRAM  = 2'd2;
    localparam logic [1:0] KIND_OTHER    = 2'd3;

    // controller to datapath
    typedef struct packed {
        logic track_rst;  // clear track state
        logic acc_take;   // shift byte into accumulator
        logic acc_clr;    // clear accumulator
        logic div_start;  // start time update with accumulator as delta
        logic set_status;
        logic set_meta;
        logic hold_d1;
        logic tempo_take;
        logic skip_load;  // load skip count from accumulator
        logic skip_dec;
        logic emit_d2;    // build result with held data and byte
        logic emit_d1;    // build result with byte and zero
    } mtep_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic       div_busy;
        logic [7:0] status;
        logic [7:0] meta;
        logic       acc_is3;
        logic       acc_zero;   // value after take is zero
        logic       skip_last;  // skip count at most one
    } mtep_stat_t;

endpackage

### hw/rtl/mtep_datapath.sv
// ----------------------------------------------------------------------------
// mtep_datapath
// Registers, time accumulator with serial divider, and result builder.
// ----------------------------------------------------------------------------
module mtep_datapath #(
    parameter int TIME_WIDTH = 48
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic [15:0]         tpq,
    input  logic [7:0]          in_byte,
    input  mtep_pkg::mtep_cmd_t cmd,
    output mtep_pkg::mtep_stat_t stat,
    output logic [1:0]          r_kind,
    output logic [7:0]          r_status,
    output logic [7:0]          r_d1,
    output logic [7:0]          r_d2,
    output logic [47:0]         r_time
);
    localparam int SW = 56;  // 32x24 product plus remainder
    localparam int QW = (TIME_WIDTH > SW) ? TIME_WIDTH : SW;
    localparam logic [TIME_WIDTH-1:0] TMAX = {TIME_WIDTH{1'b1}};

    logic [31:0] acc_reg;
    logic [7:0]  status_reg, meta_reg, held_reg;
    logic [31:0] skip_reg;
    logic [23:0] tempo_reg;
    logic [TIME_WIDTH-1:0] time_reg;
    logic [15:0] rem_reg;
    logic [SW-1:0] sum_reg;   // dividend, shifted out as quotient builds
    logic [16:0] prem_reg;    // partial remainder
    logic [5:0]  cnt_reg;
    logic        busy_reg;
    logic        mul_reg;

    logic [31:0] acc_next;
    logic [15:0] div;
    logic [16:0] trial;
    logic        qbit;
    logic [SW-1:0] q_full;
    logic [QW-1:0] q_ext;
    logic [TIME_WIDTH:0] tsum;

    // a track start byte begins a fresh number
    assign acc_next = {(cmd.track_rst ? 25'd0 : acc_reg[24:0]), in_byte[6:0]};
    assign div      = (tpq == 16'd0) ? 16'd1 : tpq;
    assign trial    = {prem_reg[15:0], sum_reg[SW-1]};
    assign qbit     = trial >= {1'b0, div};
    assign q_full   = {sum_reg[SW-2:0], qbit};
    assign q_ext    = QW'(q_full);

    // saturate the new time against TIME_WIDTH
    always_comb begin
        if ((q_ext >> TIME_WIDTH) != '0) tsum = {1'b1, TMAX};
        else tsum = {1'b0, time_reg} + {1'b0, q_ext[TIME_WIDTH-1:0]};
    end

    // parsing registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg <= '0; status_reg <= '0; meta_reg <= '0; held_reg <= '0;
            skip_reg <= '0; tempo_reg <= mtep_pkg::TEMPO_DEFAULT;
        end else begin
            if (cmd.acc_clr) acc_reg <= '0;
            else if (cmd.acc_take) acc_reg <= acc_next;
            else if (cmd.track_rst) acc_reg <= '0;
            if (cmd.track_rst) begin
                status_reg <= '0; meta_reg <= '0; held_reg <= '0;
                skip_reg <= '0; tempo_reg <= mtep_pkg::TEMPO_DEFAULT;
            end else begin
                if (cmd.set_status) status_reg <= in_byte;
                if (cmd.set_meta) meta_reg <= in_byte;
                if (cmd.hold_d1) held_reg <= in_byte;
                if (cmd.tempo_take) tempo_reg <= {tempo_reg[15:0], in_byte};
                if (cmd.skip_load) skip_reg <= acc_next;
                else if (cmd.skip_dec && skip_reg != '0) skip_reg <= skip_reg - 32'd1;
            end
        end
    end

    // time update: multiply, add the carried remainder, then 56 restoring divide steps
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0; mul_reg <= 1'b0;
            time_reg <= '0; rem_reg <= '0;
        end else if (cmd.div_start) begin
            busy_reg <= 1'b1; mul_reg <= 1'b1;
            if (cmd.track_rst) begin
                time_reg <= '0; rem_reg <= '0;
                sum_reg  <= {24'd0, acc_next} * {32'd0, mtep_pkg::TEMPO_DEFAULT};
            end else
                sum_reg  <= {24'd0, acc_next} * {32'd0, tempo_reg};
            cnt_reg <= '0;
        end else if (busy_reg && mul_reg) begin
            mul_reg  <= 1'b0;
            sum_reg  <= sum_reg + {40'd0, rem_reg};
            prem_reg <= '0;
        end else if (busy_reg) begin
            prem_reg <= qbit ? trial - {1'b0, div} : trial;
            sum_reg  <= q_full;
            cnt_reg  <= cnt_reg + 6'd1;
            if (cnt_reg == 6'(SW - 1)) begin
                busy_reg <= 1'b0;
                rem_reg  <= qbit ? 16'(trial - {1'b0, div}) : trial[15:0];
                time_reg <= tsum[TIME_WIDTH] ? TMAX : tsum[TIME_WIDTH-1:0];
            end
        end else if (cmd.track_rst) begin
            time_reg <= '0; rem_reg <= '0;
        end
    end

    // result builder
    always_ff @(posedge aclk) begin
        if (cmd.emit_d1 || cmd.emit_d2) begin
            logic [7:0] d2;
            d2 = cmd.emit_d2 ? in_byte : 8'd0;
            r_status <= status_reg;
            r_d1     <= cmd.emit_d2 ? held_reg : in_byte;
            r_d2     <= d2;
            r_time   <= 48'(time_reg);
            if (status_reg[7:4] == mtep_pkg::TYPE_NON && d2 != 8'd0)
                r_kind <= mtep_pkg::KIND_NOTE_ON;
            else if (status_reg[7:4] == mtep_pkg::TYPE_NON
                     || status_reg[7:4] == mtep_pkg::TYPE_NOFF)
                r_kind <= mtep_pkg::KIND_NOTE_OFF;
            else if (status_reg[7:4] == mtep_pkg::TYPE_PROG)
                r_kind <= mtep_pkg::KIND_PROGRAM;
            else
                r_kind <= mtep_pkg::KIND_OTHER;
        end
    end

    assign stat.div_busy  = busy_reg;
    assign stat.status    = status_reg;
    assign stat.meta      = meta_reg;
    assign stat.acc_is3   = acc_next == 32'd3;
    assign stat.acc_zero  = acc_next == 32'd0;
    assign stat.skip_last = skip_reg <= 32'd1;
endmodule

### hw/rtl/mtep_ctrl.sv
// ----------------------------------------------------------------------------
// mtep_ctrl
// Parse state machine and handshake control.
// ----------------------------------------------------------------------------
module mtep_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_fire,
    input  logic [7:0]           in_byte,
    input  logic                 in_start,
    input  logic                 out_fire,
    input  mtep_pkg::mtep_stat_t stat,
    output mtep_pkg::mtep_cmd_t  cmd,
    output logic                 in_ready,
    output logic                 out_valid
);
    localparam logic [3:0] PH_DELTA = 4'd0, PH_EVENT = 4'd1, PH_DATA1 = 4'd2,
        PH_DATA2 = 4'd3, PH_META_TYPE = 4'd4, PH_META_LEN = 4'd5,
        PH_TEMPO = 4'd6, PH_SYSEX_LEN = 4'd7, PH_SKIP = 4'd8;

    logic [3:0] ph_reg, ph_next, ph;
    logic [1:0] tcnt_reg, tcnt_next;
    logic       ov_reg, ov_next;
    logic [7:0] st;
    logic       one_byte;

    assign in_ready  = !stat.div_busy && !ov_reg;
    assign out_valid = ov_reg;
    assign ph        = in_start ? PH_DELTA : ph_reg;
    assign st        = in_start ? 8'd0 : stat.status;
    assign one_byte  = st[7:4] == mtep_pkg::TYPE_PROG || st[7:4] == mtep_pkg::TYPE_CPRS;

    // next phase and commands
    always_comb begin
        cmd       = '0;
        ph_next   = ph_reg;
        tcnt_next = in_start ? 2'd0 : tcnt_reg;
        ov_next   = ov_reg && !out_fire;
        if (in_fire) begin
            cmd.track_rst = in_start;
            ph_next = ph;
            case (ph)
                PH_DELTA: begin
                    cmd.acc_take = 1'b1;
                    if (!in_byte[7]) begin
                        cmd.div_start = 1'b1; cmd.acc_clr = 1'b1; ph_next = PH_EVENT;
                    end
                end
                PH_EVENT: begin
                    if (in_byte == mtep_pkg::BYTE_META) ph_next = PH_META_TYPE;
                    else if (in_byte == mtep_pkg::BYTE_SYSEX || in_byte == mtep_pkg::BYTE_ESC) begin
                        cmd.acc_clr = 1'b1; ph_next = PH_SYSEX_LEN;
                    end else if (in_byte[7]) begin
                        cmd.set_status = 1'b1; ph_next = PH_DATA1;
                    end else if (one_byte) begin
                        cmd.emit_d1 = 1'b1; ov_next = 1'b1; ph_next = PH_DELTA;
                    end else begin
                        cmd.hold_d1 = 1'b1; ph_next = PH_DATA2;
                    end
                end
                PH_DATA1: begin
                    if (one_byte) begin
                        cmd.emit_d1 = 1'b1; ov_next = 1'b1; ph_next = PH_DELTA;
                    end else begin
                        cmd.hold_d1 = 1'b1; ph_next = PH_DATA2;
                    end
                end
                PH_DATA2: begin
                    cmd.emit_d2 = 1'b1; ov_next = 1'b1; ph_next = PH_DELTA;
                end
                PH_META_TYPE: begin
                    cmd.set_meta = 1'b1; cmd.acc_clr = 1'b1; ph_next = PH_META_LEN;
                end
                PH_META_LEN, PH_SYSEX_LEN: begin
                    cmd.acc_take = 1'b1;
                    if (!in_byte[7]) begin
                        cmd.acc_clr = 1'b1;
                        if (ph == PH_META_LEN && stat.meta == mtep_pkg::META_TEMPO
                            && stat.acc_is3) begin
                            tcnt_next = 2'd0; ph_next = PH_TEMPO;
                        end else begin
                            cmd.skip_load = 1'b1;
                            ph_next = stat.acc_zero ? PH_DELTA : PH_SKIP;
                        end
                    end
                end
                PH_TEMPO: begin
                    cmd.tempo_take = 1'b1;
                    tcnt_next = tcnt_reg + 2'd1;
                    if (tcnt_reg == 2'd2) begin
                        tcnt_next = 2'd0; ph_next = PH_DELTA;
                    end
                end
                PH_SKIP: begin
                    cmd.skip_dec = 1'b1;
                    if (stat.skip_last) ph_next = PH_DELTA;
                end
                default: ph_next = PH_DELTA;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ph_reg <= PH_DELTA; tcnt_reg <= 2'd0; ov_reg <= 1'b0;
        end else begin
            ph_reg <= ph_next; tcnt_reg <= tcnt_next; ov_reg <= ov_next;
        end
    end
endmodule

### hw/rtl/midi_track_event_parser.sv
// ----------------------------------------------------------------------------
// midi_track_event_parser
// Parses a MIDI track body byte stream into timed channel events.
// ----------------------------------------------------------------------------
// channel  | dir | tdata                               | tuser
// s_axis   | in  | data_byte[7:0]                      | track_start
// m_axis   | out | kind,channel,status,d1,d2,time_us   | -
// cfg      | in  | division[15:0]                      | -
// Bytes are normally taken back to back. A delta-time end byte is multiplied by the
// tempo as it is taken; a step then adds the carried remainder and 56 restoring
// divide steps follow, and no byte is taken until the last of them is done.
// A result is held in the output register; no byte is taken until it is taken.
// Reset is synchronous, active low; no clearing pass.
module midi_track_event_parser #(
    parameter int TIME_WIDTH = 48
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // data_byte
    input  logic        s_axis_tuser,   // track_start
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // event_kind[1:0], channel[5:2], status_byte[13:6], first_data[21:14],
    // second_data[29:22], time_us[77:30], zero fill
    output logic [79:0] m_axis_tdata,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data
);
    logic [15:0] tpq_reg;
    mtep_pkg::mtep_cmd_t  cmd;
    mtep_pkg::mtep_stat_t stat;
    logic [1:0]  r_kind;
    logic [7:0]  r_status, r_d1, r_d2;
    logic [47:0] r_time;

    assign cfg_ready = 1'b1;

    // configuration register
    always_ff @(posedge aclk) begin
        if (!aresetn) tpq_reg <= mtep_pkg::TPQ_DEFAULT;
        else if (cfg_valid) tpq_reg <= cfg_data;
    end

    mtep_ctrl u_ctrl (
        .aclk, .aresetn,
        .in_fire (s_axis_tvalid && s_axis_tready),
        .in_byte (s_axis_tdata),
        .in_start(s_axis_tuser),
        .out_fire(m_axis_tvalid && m_axis_tready),
        .stat, .cmd,
        .in_ready(s_axis_tready),
        .out_valid(m_axis_tvalid)
    );

    mtep_datapath #(.TIME_WIDTH(TIME_WIDTH)) u_dp (
        .aclk, .aresetn, .tpq(tpq_reg), .in_byte(s_axis_tdata),
        .cmd, .stat, .r_kind, .r_status, .r_d1, .r_d2, .r_time
    );

    assign m_axis_tdata = {2'b00, r_time, r_d2, r_d1, r_status, r_status[3:0], r_kind};
endmodule
